// ----- src/abrf_pkg.sv -----
// Shared constants, types and helper functions for the alpha blend rectangle fill engine.
`default_nettype none

package abrf_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int PIX_W     = 24;
    localparam int CHAN_W    = 8;
    localparam int COLOR_W   = 32;
    localparam int MODE_W    = 2;
    localparam int CRD_W     = 10;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_W     = 17;
    localparam int SCRN_W    = CRD_W + 2;
    localparam int PROD_W    = 2 * CHAN_W;

    localparam logic [CFG_W-1:0]     SCREEN_RESET   = CFG_W'(256);
    localparam logic [CHAN_W-1:0]    ALPHA_FULL     = 8'hFF;
    localparam logic [CHAN_W-1:0]    PATTERN_OFFSET = 8'hA0;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

    localparam logic [MODE_W-1:0] MODE_FILL_COLOR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FILL_BG    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ       = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_FILL,
        ST_DRAIN,
        ST_READ,
        ST_RWAIT,
        ST_DONE
    } state_t;

    // floor(v / 255), exact for v below 65280
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W:0] v);
        logic [PROD_W:0] t;
        t = v + (v >> CHAN_W) + (PROD_W+1)'(1);
        return t[PROD_W-1:CHAN_W];
    endfunction

    function automatic logic [PIX_W-1:0] bg_pattern(input logic [CFG_W-1:0] x,
                                                    input logic [CFG_W-1:0] y);
        logic [CFG_W-1:0]  xy;
        logic [CHAN_W-1:0] t;
        xy = x ^ y;
        t  = CHAN_W'(xy >> 2) + PATTERN_OFFSET;
        return {1'b0, t[CHAN_W-1:1], 16'h0000} | {7'b0, t, 9'b0} | {16'h0000, t};
    endfunction

endpackage

`default_nettype wire

// ----- src/abrf_if.sv -----
// Command and response channel interfaces of the fill engine.
`default_nettype none

interface abrf_cmd_if;
    import abrf_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [MODE_W-1:0]          mode;
    logic signed [CRD_W-1:0]    x_start;
    logic signed [CRD_W-1:0]    y_start;
    logic [CFG_W-1:0]           rect_width;
    logic [CFG_W-1:0]           rect_height;
    logic [COLOR_W-1:0]         fill_color;

    modport source (output valid, mode, x_start, y_start, rect_width, rect_height,
                    fill_color, input ready);
    modport sink   (input valid, mode, x_start, y_start, rect_width, rect_height,
                    fill_color, output ready);
endinterface

interface abrf_rsp_if;
    import abrf_pkg::*;
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   read_pixel;
    logic               read_valid;
    logic [CNT_W-1:0]   pixels_written;

    modport source (output valid, read_pixel, read_valid, pixels_written, input ready);
    modport sink   (input valid, read_pixel, read_valid, pixels_written, output ready);
endinterface

`default_nettype wire

// ----- src/alpha_blend_rect_fill.sv -----
// Top level of the alpha blend rectangle fill engine over a 24-bit frame store.
//
//  Channel   Direction  Handshake          Payload
//  cmd       in         valid/ready        mode, x_start, y_start, rect_width,
//                                          rect_height, fill_color
//  rsp       out        valid/ready        read_pixel, read_valid, pixels_written
//  cfg       in         cfg_we             cfg_index, cfg_wdata
//
//  After acceptance: SETUP, then FILL and DRAIN for a fill, READ and RWAIT for a read,
//  nothing for an empty fill; the result is loaded in DONE, then IDLE takes the next item.
//  The single frame store port pair sets the rate: one pixel read-modify-write per cycle.
//  After reset a clearing pass writes zero to all STORE_DEPTH (65536) entries, one per
//  cycle; cmd.ready stays low meanwhile, configuration writes are taken.
//  One item is in work at a time; the next is taken while the last result waits on rsp.
`default_nettype none

module alpha_blend_rect_fill (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [abrf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [abrf_pkg::CFG_W-1:0]     cfg_wdata,
    abrf_cmd_if.sink                            cmd,
    abrf_rsp_if.source                          rsp
);
    import abrf_pkg::*;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [CFG_W-1:0]   sw_reg, sh_reg;
    logic [CFG_W-1:0]   w_eff, h_eff;

    logic [MODE_W-1:0]  mode_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               work_reg;
    logic [CFG_W-1:0]   x0_reg, x_end_reg, y_end_reg, x_reg, y_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PIX_W-1:0]   rd_pix_reg;

    logic               s1_valid_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic [PIX_W-1:0]   s1_src_reg;
    logic [CHAN_W-1:0]  s1_alpha_reg;

    logic               s2_valid_reg;
    logic [ADDR_W-1:0]  s2_addr_reg;
    logic [PIX_W-1:0]   s2_src_reg;
    logic               s2_bypass_reg;
    logic [PROD_W-1:0]  s2_dp_reg [3];
    logic [PROD_W-1:0]  s2_sp_reg [3];

    logic               rsp_valid_reg;
    logic [PIX_W-1:0]   rsp_pix_reg;
    logic               rsp_rv_reg;
    logic [CNT_W-1:0]   rsp_cnt_reg;

    logic signed [SCRN_W-1:0] xs_e, ys_e, rw_e, rh_e, w_s, h_s;
    logic signed [SCRN_W-1:0] x0_s, y0_s, x1_s, y1_s, xe_s, ye_s;
    logic               fill_ok, read_ok, cmd_work;

    logic [2*CFG_W-1:0] row_prod;
    logic               last_x, last_y;
    logic [ADDR_W-1:0]  pix_addr;
    logic [PIX_W-1:0]   issue_src;
    logic [CHAN_W-1:0]  issue_alpha;
    logic [PIX_W-1:0]   blend_pix;

    logic               cmd_take;
    logic               issue;
    logic               rsp_load;
    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [PIX_W-1:0]   ram_wdata, ram_rdata;

    abrf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // clip the incoming rectangle against the visible screen and decide whether the item has work
    always_comb
    begin
        w_eff = (int'(sw_reg) > MAX_WIDTH)  ? CFG_W'(MAX_WIDTH)  : sw_reg;
        h_eff = (int'(sh_reg) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : sh_reg;
        xs_e  = {{(SCRN_W-CRD_W){cmd.x_start[CRD_W-1]}}, cmd.x_start};
        ys_e  = {{(SCRN_W-CRD_W){cmd.y_start[CRD_W-1]}}, cmd.y_start};
        rw_e  = {{(SCRN_W-CFG_W){1'b0}}, cmd.rect_width};
        rh_e  = {{(SCRN_W-CFG_W){1'b0}}, cmd.rect_height};
        w_s   = {{(SCRN_W-CFG_W){1'b0}}, w_eff};
        h_s   = {{(SCRN_W-CFG_W){1'b0}}, h_eff};
        xe_s  = xs_e + rw_e;
        ye_s  = ys_e + rh_e;
        x0_s  = xs_e[SCRN_W-1] ? '0 : xs_e;
        y0_s  = ys_e[SCRN_W-1] ? '0 : ys_e;
        x1_s  = (xe_s > w_s) ? w_s : xe_s;
        y1_s  = (ye_s > h_s) ? h_s : ye_s;
        fill_ok = (x0_s < x1_s) && (y0_s < y1_s);
        read_ok = !xs_e[SCRN_W-1] && !ys_e[SCRN_W-1] && (xs_e < w_s) && (ys_e < h_s);
        case (cmd.mode)
            MODE_FILL_COLOR: cmd_work = fill_ok;
            MODE_FILL_BG:    cmd_work = fill_ok;
            MODE_READ:       cmd_work = read_ok;
            default:         cmd_work = 1'b0;
        endcase
    end

    always_comb
    begin
        row_prod    = {{CFG_W{1'b0}}, y_reg} * {{CFG_W{1'b0}}, w_eff};
        pix_addr    = base_reg + ADDR_W'(x_reg);
        last_x      = ({1'b0, x_reg} + (CFG_W+1)'(1)) == {1'b0, x_end_reg};
        last_y      = ({1'b0, y_reg} + (CFG_W+1)'(1)) == {1'b0, y_end_reg};
        if (mode_reg == MODE_FILL_COLOR)
        begin
            issue_src   = color_reg[PIX_W-1:0];
            issue_alpha = color_reg[COLOR_W-1:PIX_W];
        end
        else
        begin
            issue_src   = bg_pattern(x_reg, y_reg);
            issue_alpha = '0;
        end
        for (int c = 0; c < 3; c++)
        begin
            blend_pix[c*CHAN_W +: CHAN_W] =
                div255({1'b0, s2_dp_reg[c]} + {1'b0, s2_sp_reg[c]});
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (!work_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (mode_reg == MODE_READ)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (last_x && last_y)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:  state_next = ST_RWAIT;
            ST_RWAIT: state_next = ST_DONE;
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        cmd_take  = 1'b0;
        issue     = 1'b0;
        rsp_load  = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = pix_addr;
        ram_we    = s2_valid_reg;
        ram_waddr = s2_addr_reg;
        ram_wdata = s2_bypass_reg ? s2_src_reg : blend_pix;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_IDLE:  cmd_take = cmd.valid;
            ST_FILL:
            begin
                issue  = 1'b1;
                ram_re = 1'b1;
            end
            ST_READ:  ram_re = 1'b1;
            ST_DONE:  rsp_load = !rsp_valid_reg || rsp.ready;
            default:  ;
        endcase
    end

    assign cmd.ready          = (state_reg == ST_IDLE);
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.read_pixel     = rsp_pix_reg;
    assign rsp.read_valid     = rsp_rv_reg;
    assign rsp.pixels_written = rsp_cnt_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            sw_reg        <= SCREEN_RESET;
            sh_reg        <= SCREEN_RESET;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SCREEN_WIDTH:  sw_reg <= cfg_wdata;
                    REG_SCREEN_HEIGHT: sh_reg <= cfg_wdata;
                    default:           ;
                endcase
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // item and pixel datapath
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            mode_reg   <= cmd.mode;
            color_reg  <= cmd.fill_color;
            work_reg   <= cmd_work;
            x0_reg     <= x0_s[CFG_W-1:0];
            x_reg      <= x0_s[CFG_W-1:0];
            y_reg      <= y0_s[CFG_W-1:0];
            x_end_reg  <= x1_s[CFG_W-1:0];
            y_end_reg  <= y1_s[CFG_W-1:0];
            count_reg  <= '0;
            rd_pix_reg <= '0;
        end
        if (state_reg == ST_SETUP)
        begin
            base_reg <= ADDR_W'(row_prod);
        end
        if (issue)
        begin
            count_reg <= count_reg + CNT_W'(1);
            if (last_x)
            begin
                x_reg    <= x0_reg;
                y_reg    <= y_reg + CFG_W'(1);
                base_reg <= base_reg + ADDR_W'(w_eff);
            end
            else
            begin
                x_reg <= x_reg + CFG_W'(1);
            end
        end
        if (state_reg == ST_RWAIT)
        begin
            rd_pix_reg <= ram_rdata;
        end

        s1_addr_reg  <= pix_addr;
        s1_src_reg   <= issue_src;
        s1_alpha_reg <= issue_alpha;

        s2_addr_reg   <= s1_addr_reg;
        s2_src_reg    <= s1_src_reg;
        s2_bypass_reg <= (s1_alpha_reg == '0);
        for (int c = 0; c < 3; c++)
        begin
            s2_dp_reg[c] <= PROD_W'(ram_rdata[c*CHAN_W +: CHAN_W])
                          * PROD_W'(ALPHA_FULL - s1_alpha_reg);
            s2_sp_reg[c] <= PROD_W'(s1_src_reg[c*CHAN_W +: CHAN_W])
                          * PROD_W'(s1_alpha_reg);
        end

        if (rsp_load)
        begin
            rsp_pix_reg <= rd_pix_reg;
            rsp_rv_reg  <= work_reg && (mode_reg == MODE_READ);
            rsp_cnt_reg <= count_reg;
        end
    end

endmodule

`default_nettype wire

// ----- src/abrf_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module abrf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/abrf_checker.sv -----
// Port-level checker for the fill engine and its bind to the top level.
`default_nettype none

module abrf_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          cmd_valid,
    input wire logic                          cmd_ready,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [abrf_pkg::PIX_W-1:0]    rsp_read_pixel,
    input wire logic                          rsp_read_valid,
    input wire logic [abrf_pkg::CNT_W-1:0]    rsp_pixels_written
);
    import abrf_pkg::*;

    // hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_pixel)
            && $stable(rsp_read_valid) && $stable(rsp_pixels_written))
        else $error("stalled result changed");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("second item taken while one is in work");

    a_read_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_read_valid |-> rsp_pixels_written == '0)
        else $error("read result carries a pixel count");

    a_invalid_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_read_valid |-> rsp_read_pixel == '0)
        else $error("pixel data without a valid read");

    a_fill_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_pixels_written != '0 |-> !rsp_read_valid)
        else $error("fill result flagged as read");

endmodule

bind alpha_blend_rect_fill abrf_checker u_abrf_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (cmd.valid),
    .cmd_ready          (cmd.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_read_pixel     (rsp.read_pixel),
    .rsp_read_valid     (rsp.read_valid),
    .rsp_pixels_written (rsp.pixels_written)
);

`default_nettype wire
